/* src/mbst_pkg.sv */
// Shared types and codes of the minimal bitset subsumption table.
package mbst_pkg;

    localparam int VEC_MAX   = 64;
    localparam int COUNT_W   = 7;
    localparam int COUNT_MAX = 127;

    localparam logic [1:0] FN_ADD      = 2'd0;
    localparam logic [1:0] FN_SUBSET   = 2'd1;
    localparam logic [1:0] FN_SUPERSET = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [VEC_MAX-1:0] vector_bits;
    } mbst_req_t;

    typedef struct packed {
        logic               found;
        logic               inserted;
        logic [COUNT_W-1:0] removed_count;
        logic               overflow;
        logic [COUNT_W-1:0] entries_held;
    } mbst_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } mbst_state_t;

    typedef struct packed {
        logic start;
        logic scan;
    } mbst_head_ctrl_t;

endpackage

/* src/mbst_cell.sv */
// One storage cell of the entry ring: shifts towards the head, loads on a write.
module mbst_cell #(
    parameter int VECTOR_WIDTH = 64,
    parameter int IDX_W        = 6,
    parameter int CELL_INDEX   = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift,
    input  logic [VECTOR_WIDTH-1:0] nbr_bits,
    input  logic                    nbr_valid,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_idx,
    input  logic [VECTOR_WIDTH-1:0] wr_bits,
    output logic [VECTOR_WIDTH-1:0] bits,
    output logic                    valid
);

    logic [VECTOR_WIDTH-1:0] bits_reg;
    logic                    valid_reg;
    logic                    hit_wr;

    assign hit_wr = wr_en && (wr_idx == IDX_W'(CELL_INDEX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= nbr_valid;
        end
        else if (hit_wr)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            bits_reg <= nbr_bits;
        end
        else if (hit_wr)
        begin
            bits_reg <= wr_bits;
        end
    end

    assign bits  = bits_reg;
    assign valid = valid_reg;

endmodule

/* src/mbst_head.sv */
// Compare unit at the head of the ring: tests each passing entry and keeps the scan tallies.
module mbst_head #(
    parameter int VECTOR_WIDTH = 64,
    parameter int IDX_W        = 6,
    parameter int CNT_W        = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mbst_pkg::mbst_head_ctrl_t ctrl,
    input  logic [1:0]              func,
    input  logic [VECTOR_WIDTH-1:0] vec,
    input  logic [IDX_W-1:0]        step,
    input  logic [VECTOR_WIDTH-1:0] head_bits,
    input  logic                    head_valid,
    output logic                    keep_valid,
    output logic                    found,
    output logic [CNT_W-1:0]        removed,
    output logic                    free_found,
    output logic [IDX_W-1:0]        free_idx
);

    logic             sub_hit;
    logic             sup_hit;
    logic             erase;
    logic             hit;
    logic             found_reg;
    logic [CNT_W-1:0] removed_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    assign sub_hit = head_valid && ((head_bits & ~vec) == '0);
    assign sup_hit = head_valid && ((vec & ~head_bits) == '0);

    // Drop strict supersets only; an equal entry means the add is subsumed.
    assign erase      = ctrl.scan && (func == mbst_pkg::FN_ADD) && sup_hit && !sub_hit;
    assign keep_valid = head_valid && !erase;

    always_comb
    begin
        case (func)
            mbst_pkg::FN_ADD:      hit = sub_hit;
            mbst_pkg::FN_SUBSET:   hit = sub_hit;
            mbst_pkg::FN_SUPERSET: hit = sup_hit;
            default:               hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            removed_reg    <= '0;
            free_found_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            found_reg      <= 1'b0;
            removed_reg    <= '0;
            free_found_reg <= 1'b0;
        end
        else if (ctrl.scan)
        begin
            if (hit)
            begin
                found_reg <= 1'b1;
            end
            if (erase)
            begin
                removed_reg <= removed_reg + CNT_W'(1);
            end
            if (!free_found_reg && !keep_valid)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scan && !free_found_reg && !keep_valid)
        begin
            free_idx_reg <= step;
        end
    end

    assign found      = found_reg;
    assign removed    = removed_reg;
    assign free_found = free_found_reg;
    assign free_idx   = free_idx_reg;

endmodule

/* src/minimal_bitset_subsumption_table_core.sv */
// Top level of the minimal bitset subsumption table: entry ring, head unit and control.
//
// Use: a request item carries func (add, ask for stored subset, ask for stored
// superset) and a bit vector; each request gives exactly one response item with
// found, inserted, removed_count, overflow and entries_held. Both channels are
// valid/ready; an item moves when valid and ready are high at a rising edge.
//
// The entries sit in a ring of TABLE_DEPTH cells that, while scanning, rotates one
// place per cycle past a single compare head, so every entry is tested once per
// item and the ring is back in place after a full turn. The turn sets the timing:
// a request is taken in idle, the ring turns once in the scan state and the finish
// state registers the response, then idle takes the next one. Strict supersets are
// erased as they pass the head; an insert goes into the lowest free slot at the end.
//
// Reset clears every valid flag, the entry count and the response valid flag at
// once; there is no clearing pass. A request is taken while an earlier response
// still waits in the output register; if the receiver stalls, the finished scan
// holds until the response register is free.
module minimal_bitset_subsumption_table_core #(
    parameter int VECTOR_WIDTH = 64,
    parameter int TABLE_DEPTH  = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mbst_pkg::mbst_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mbst_pkg::mbst_rsp_t rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = mbst_pkg::COUNT_W;

    // Clamp a count to the response field.
    function automatic logic [CW-1:0] sat_count(input logic [CNT_W-1:0] n);
        logic [CW-1:0] r;
        if (32'(n) > mbst_pkg::COUNT_MAX)
        begin
            r = CW'(mbst_pkg::COUNT_MAX);
        end
        else
        begin
            r = CW'(n);
        end
        return r;
    endfunction

    mbst_pkg::mbst_state_t     state_reg, state_next;
    mbst_pkg::mbst_head_ctrl_t head_ctrl;

    logic [IDX_W-1:0]        step_reg;
    logic [1:0]              func_reg;
    logic [VECTOR_WIDTH-1:0] vec_reg;
    logic [CNT_W-1:0]        held_reg, held_next;
    mbst_pkg::mbst_rsp_t     rsp_reg, rsp_next;
    logic                    rsp_valid_reg;

    logic req_fire;
    logic scan_last;
    logic finish_fire;
    logic is_add;
    logic do_insert;
    logic do_overflow;

    logic [VECTOR_WIDTH-1:0] cell_bits  [TABLE_DEPTH];
    logic                    cell_valid [TABLE_DEPTH];

    logic                    keep_valid;
    logic                    head_found;
    logic [CNT_W-1:0]        head_removed;
    logic                    head_free_found;
    logic [IDX_W-1:0]        head_free_idx;

    assign req_fire  = req_valid && req_ready;
    assign scan_last = (step_reg == IDX_W'(TABLE_DEPTH - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbst_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = mbst_pkg::ST_SCAN;
                end
            end
            mbst_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = mbst_pkg::ST_FINISH;
                end
            end
            mbst_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = mbst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbst_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        req_ready      = 1'b0;
        head_ctrl      = '0;
        finish_fire    = 1'b0;
        case (state_reg)
            mbst_pkg::ST_IDLE:
            begin
                req_ready       = 1'b1;
                head_ctrl.start = req_valid;
            end
            mbst_pkg::ST_SCAN:
            begin
                head_ctrl.scan = 1'b1;
            end
            mbst_pkg::ST_FINISH:
            begin
                finish_fire = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Settle the add once the whole ring has passed the head.
    assign is_add      = (func_reg == mbst_pkg::FN_ADD);
    assign do_insert   = finish_fire && is_add && !head_found && head_free_found;
    assign do_overflow = is_add && !head_found && !head_free_found;

    always_comb
    begin
        held_next = held_reg - head_removed + CNT_W'(do_insert);
        rsp_next.found         = head_found;
        rsp_next.inserted      = is_add && !head_found && head_free_found;
        rsp_next.removed_count = sat_count(head_removed);
        rsp_next.overflow      = do_overflow;
        rsp_next.entries_held  = sat_count(held_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbst_pkg::ST_IDLE;
            step_reg      <= '0;
            held_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire)
            begin
                step_reg <= '0;
            end
            else if (head_ctrl.scan && !scan_last)
            begin
                step_reg <= step_reg + IDX_W'(1);
            end
            if (finish_fire)
            begin
                held_reg      <= held_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the operand for the whole scan; drop bits above the vector width.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg <= req.func;
            vec_reg  <= req.vector_bits[VECTOR_WIDTH-1:0];
        end
        if (finish_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Ring of cells: each takes its upper neighbour, the last takes the head entry
    // with its valid flag after any erase.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [VECTOR_WIDTH-1:0] nbr_bits;
        logic                    nbr_valid;

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign nbr_bits  = cell_bits[0];
            assign nbr_valid = keep_valid;
        end
        else
        begin : g_mid
            assign nbr_bits  = cell_bits[i+1];
            assign nbr_valid = cell_valid[i+1];
        end

        mbst_cell #(
            .VECTOR_WIDTH (VECTOR_WIDTH),
            .IDX_W        (IDX_W),
            .CELL_INDEX   (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (head_ctrl.scan),
            .nbr_bits  (nbr_bits),
            .nbr_valid (nbr_valid),
            .wr_en     (do_insert),
            .wr_idx    (head_free_idx),
            .wr_bits   (vec_reg),
            .bits      (cell_bits[i]),
            .valid     (cell_valid[i])
        );
    end

    mbst_head #(
        .VECTOR_WIDTH (VECTOR_WIDTH),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_head (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (head_ctrl),
        .func       (func_reg),
        .vec        (vec_reg),
        .step       (step_reg),
        .head_bits  (cell_bits[0]),
        .head_valid (cell_valid[0]),
        .keep_valid (keep_valid),
        .found      (head_found),
        .removed    (head_removed),
        .free_found (head_free_found),
        .free_idx   (head_free_idx)
    );

endmodule

/* bench/minimal_bitset_subsumption_table_core_tb.sv */
// Self-checking testbench for the minimal bitset subsumption table core.
`timescale 1ns / 1ps

module minimal_bitset_subsumption_table_core_tb;

    // Block configuration under test
    localparam int VECTOR_WIDTH = 64;
    localparam int TABLE_DEPTH  = 64;
    localparam int VW           = mbst_pkg::VEC_MAX;
    localparam int CW           = mbst_pkg::COUNT_W;

    // Selector value with no operation behind it
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // Operand bits at and above VECTOR_WIDTH never reach the table
    localparam logic [VW-1:0] VEC_MASK = {VW{1'b1}} >> (VW - VECTOR_WIDTH);

    // Each item takes a full turn of the entry ring, so allow a generous margin
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_WAIT  = TABLE_DEPTH + 8;

    // Randomisation targets (items accepted)
    localparam int RANDOM_ITEMS = 1130;
    localparam int STEADY_ITEMS = 200;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    mbst_pkg::mbst_req_t req;
    logic                rsp_valid;
    logic                rsp_ready;
    mbst_pkg::mbst_rsp_t rsp;

    // Shadow copy of the table, updated in acceptance order
    logic [VW-1:0] shadow_bits  [TABLE_DEPTH];
    logic          shadow_valid [TABLE_DEPTH];

    // Responses the table owes us, oldest first
    mbst_pkg::mbst_rsp_t owed_rsp[$];

    int  cycle_count;
    int  error_count;
    int  items_sent;
    int  rsp_seen;
    bit  no_idle;

    minimal_bitset_subsumption_table_core #(
        .VECTOR_WIDTH (VECTOR_WIDTH),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run: a stuck handshake must not spin forever
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses still owed",
                     cycle_count, owed_rsp.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic logic [CW-1:0] clamp_count(input int n);
        int m;
        m = (n > mbst_pkg::COUNT_MAX) ? mbst_pkg::COUNT_MAX : n;
        return m[CW-1:0];
    endfunction

    function automatic int held_entries();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (shadow_valid[i])
                n++;
        return n;
    endfunction

    // True when some live entry holds no bit outside v
    function automatic bit holds_subset_of(input logic [VW-1:0] v);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (shadow_valid[i] && ((shadow_bits[i] & ~v) == '0))
                return 1'b1;
        return 1'b0;
    endfunction

    // Apply one accepted item to the shadow table and return its response
    function automatic mbst_pkg::mbst_rsp_t apply_table_item(input mbst_pkg::mbst_req_t item);
        mbst_pkg::mbst_rsp_t res;
        logic [VW-1:0]       v;
        int                  removed;
        int                  slot;
        v       = item.vector_bits & VEC_MASK;
        res     = '0;
        removed = 0;
        slot    = -1;
        case (item.func)
            mbst_pkg::FN_ADD:
            begin
                if (holds_subset_of(v))
                    res.found = 1'b1;
                else
                begin
                    // Erase every superset first, then take the lowest free slot
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (shadow_valid[i] && ((v & ~shadow_bits[i]) == '0))
                        begin
                            shadow_valid[i] = 1'b0;
                            removed++;
                        end
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (!shadow_valid[i] && slot < 0)
                            slot = i;
                    if (slot >= 0)
                    begin
                        shadow_bits[slot]  = v;
                        shadow_valid[slot] = 1'b1;
                        res.inserted       = 1'b1;
                    end
                    else
                        res.overflow = 1'b1;
                end
            end
            mbst_pkg::FN_SUBSET:
                res.found = holds_subset_of(v);
            mbst_pkg::FN_SUPERSET:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (shadow_valid[i] && ((v & ~shadow_bits[i]) == '0))
                        res.found = 1'b1;
            end
            default:
                ; // unused selector: no operation, count only
        endcase
        res.removed_count = clamp_count(removed);
        res.entries_held  = clamp_count(held_entries());
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Vector sources
    // ------------------------------------------------------------------
    function automatic logic [VW-1:0] rand_vec();
        return {$urandom, $urandom};
    endfunction

    // About three bits in four set: rarely comparable with one another
    function automatic logic [VW-1:0] dense_vec();
        return rand_vec() | rand_vec();
    endfunction

    // About one bit in eight set
    function automatic logic [VW-1:0] sparse_vec();
        return rand_vec() & rand_vec() & rand_vec();
    endfunction

    // A live entry picked at random; fall back to a dense vector on an empty table
    function automatic logic [VW-1:0] live_entry();
        int start;
        int idx;
        start = $urandom_range(0, TABLE_DEPTH - 1);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            idx = (start + i) % TABLE_DEPTH;
            if (shadow_valid[idx])
                return shadow_bits[idx];
        end
        return dense_vec();
    endfunction

    // Operand for a query: near a live entry on either side, or unrelated
    function automatic logic [VW-1:0] probe_vec();
        case ($urandom_range(0, 5))
            0:       return live_entry() | sparse_vec();
            1:       return live_entry() & ~sparse_vec();
            2:       return live_entry();
            3:       return dense_vec();
            4:       return sparse_vec();
            default: return rand_vec();
        endcase
    endfunction

    // Operand for an add meant to erase: intersection of entries, or a trimmed entry.
    // Keep it wide enough that it does not swallow most later adds.
    function automatic logic [VW-1:0] shrink_vec();
        logic [VW-1:0] v;
        int            ways;
        if ($urandom_range(0, 1) == 0)
        begin
            ways = $urandom_range(2, 4);
            v    = live_entry();
            repeat (ways - 1)
                v = v & live_entry();
        end
        else
            v = live_entry() & ~sparse_vec();
        if ($countones(v) < 16)
        begin
            v = live_entry();
            v[$urandom_range(0, VW - 1)] = 1'b0;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and response checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("ERROR response %0d: %s got %0d, want %0d (cycle %0d)",
                 rsp_seen, what, got, want, cycle_count);
        error_count++;
    endtask

    // Sample at the rising edge: compare every delivered item with the oldest owed one
    always @(posedge clk)
    begin : check_response
        mbst_pkg::mbst_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (owed_rsp.size() == 0)
                report_mismatch("response with none owed, entries_held",
                                rsp.entries_held, 0);
            else
            begin
                want = owed_rsp.pop_front();
                if (rsp.found !== want.found)
                    report_mismatch("found", rsp.found, want.found);
                if (rsp.inserted !== want.inserted)
                    report_mismatch("inserted", rsp.inserted, want.inserted);
                if (rsp.removed_count !== want.removed_count)
                    report_mismatch("removed_count", rsp.removed_count, want.removed_count);
                if (rsp.overflow !== want.overflow)
                    report_mismatch("overflow", rsp.overflow, want.overflow);
                if (rsp.entries_held !== want.entries_held)
                    report_mismatch("entries_held", rsp.entries_held, want.entries_held);
            end
            rsp_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall at random, now and then for a whole scan
    // ------------------------------------------------------------------
    initial
    begin : drive_rsp_ready
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (no_idle)
                rsp_ready <= 1'b1;
            else if ($urandom_range(0, 1999) == 0)
            begin
                // Long stall: hold the finished scan back behind a full response register
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, TABLE_DEPTH + 16))
                    @(negedge clk);
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= 6);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Drive one item at the falling edge, hold it until taken, then drop valid.
    // The random gap moves the arrival across every phase of the ring's turn.
    task automatic send_item(input logic [1:0] fn, input logic [VW-1:0] bits);
        mbst_pkg::mbst_req_t item;
        mbst_pkg::mbst_rsp_t owed;
        int                  gap;
        item.func        = fn;
        item.vector_bits = bits;
        if (!no_idle)
        begin
            gap = 0;
            while ($urandom_range(0, 99) < 7)
                gap++;
            if ($urandom_range(0, 39) == 0)
                gap += $urandom_range(1, TABLE_DEPTH + 2);
            repeat (gap)
                @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        forever
        begin
            @(posedge clk);
            if (req_ready)
                break;
        end
        owed     = apply_table_item(item);
        owed_rsp = {owed_rsp, owed};
        items_sent++;
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic wait_all_answered();
        while (owed_rsp.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Queries and the unused selector on a freshly reset, empty table
    task automatic test_empty_table();
        send_item(mbst_pkg::FN_SUBSET, '1);
        send_item(mbst_pkg::FN_SUPERSET, '0);
        send_item(mbst_pkg::FN_SUPERSET, '1);
        send_item(FN_UNUSED, '1);
    endtask

    // Every operation with the field extremes: equal add, erase by a subset,
    // subsumed add, incomparable insert, both queries both ways, unused selector
    task automatic test_operations();
        send_item(mbst_pkg::FN_ADD, '1);
        send_item(mbst_pkg::FN_ADD, '1);
        send_item(mbst_pkg::FN_SUBSET, '0);
        send_item(mbst_pkg::FN_SUPERSET, '0);
        send_item(mbst_pkg::FN_SUBSET, '1);
        send_item(mbst_pkg::FN_SUPERSET, '1);
        send_item(mbst_pkg::FN_ADD, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(mbst_pkg::FN_ADD, '1);
        send_item(mbst_pkg::FN_ADD, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(mbst_pkg::FN_SUPERSET, 64'h8000_0000_0000_0000);
        send_item(mbst_pkg::FN_SUBSET, '1);
        send_item(mbst_pkg::FN_SUBSET, 64'h5555_5555_5555_5555);
        send_item(FN_UNUSED, '1);
        send_item(FN_UNUSED, '0);
        // Erases both wide entries at once
        send_item(mbst_pkg::FN_ADD, 64'h7FFF_FFFF_FFFF_FFFE);
    endtask

    // Mixed bursts: filling runs, query runs near live entries, erasing adds,
    // repeat adds that are subsumed, and a trickle of arbitrary items
    task automatic test_random_traffic(input int target);
        int pick;
        int len;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                len = $urandom_range(5, 30);
                repeat (len)
                    send_item(mbst_pkg::FN_ADD, dense_vec());
            end
            else if (pick < 60)
            begin
                len = $urandom_range(5, 20);
                repeat (len)
                    send_item($urandom_range(0, 1) ? mbst_pkg::FN_SUBSET
                                                   : mbst_pkg::FN_SUPERSET, probe_vec());
            end
            else if (pick < 78)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                    send_item(mbst_pkg::FN_ADD, shrink_vec());
            end
            else if (pick < 93)
            begin
                len = $urandom_range(3, 10);
                repeat (len)
                    send_item(mbst_pkg::FN_ADD,
                              live_entry() | ($urandom_range(0, 1) ? sparse_vec() : '0));
            end
            else
            begin
                // Arbitrary items; narrow adds stay rare so the table keeps churning
                len = $urandom_range(2, 8);
                repeat (len)
                begin
                    case ($urandom_range(0, 9))
                        0:       send_item(mbst_pkg::FN_ADD, sparse_vec() | 64'h1);
                        1, 2, 3: send_item(mbst_pkg::FN_ADD, rand_vec());
                        4:       send_item(FN_UNUSED, rand_vec());
                        default: send_item(2'($urandom_range(1, 3)), rand_vec());
                    endcase
                end
            end
        end
    endtask

    // Hold the sender back until the table has answered everything, then resume
    task automatic test_drain_then_send();
        repeat (4)
        begin
            repeat ($urandom_range(2, 6))
                send_item(2'($urandom_range(0, 2)), probe_vec());
            wait_all_answered();
            send_item(mbst_pkg::FN_ADD, dense_vec());
        end
    endtask

    // A long stretch with neither side idling
    task automatic test_steady_stream(input int count);
        no_idle = 1'b1;
        repeat (count)
        begin
            case ($urandom_range(0, 5))
                0, 1:    send_item(mbst_pkg::FN_ADD, dense_vec());
                2:       send_item(mbst_pkg::FN_ADD, shrink_vec());
                default: send_item(2'($urandom_range(1, 2)), probe_vec());
            endcase
        end
        no_idle = 1'b0;
    endtask

    // Fill to the last slot, overflow it, then clear everything with the empty vector
    task automatic test_full_then_clear();
        int tries;
        tries = 0;
        while (held_entries() < TABLE_DEPTH && tries < 600)
        begin
            send_item(mbst_pkg::FN_ADD, dense_vec());
            tries++;
        end
        repeat (3)
            send_item(mbst_pkg::FN_ADD, dense_vec());
        send_item(mbst_pkg::FN_SUBSET, '1);
        // The empty vector sits below everything: erases the lot and stays alone
        send_item(mbst_pkg::FN_ADD, '0);
        send_item(mbst_pkg::FN_SUBSET, rand_vec());
        send_item(mbst_pkg::FN_ADD, dense_vec());
        send_item(mbst_pkg::FN_SUPERSET, 64'h1);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        no_idle     = 1'b0;
        cycle_count = 0;
        error_count = 0;
        items_sent  = 0;
        rsp_seen    = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_bits[i]  = '0;
            shadow_valid[i] = 1'b0;
        end

        // Release reset away from the active edge
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_operations();
        test_random_traffic(RANDOM_ITEMS);
        test_drain_then_send();
        test_steady_stream(STEADY_ITEMS);
        test_full_then_clear();

        // Let the last scan finish and catch any stray response
        wait_all_answered();
        repeat (SETTLE_WAIT)
            @(posedge clk);

        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
src/mbst_pkg.sv
src/mbst_cell.sv
src/mbst_head.sv
src/minimal_bitset_subsumption_table_core.sv
bench/minimal_bitset_subsumption_table_core_tb.sv
